// ===== design/pic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

   // Operation codes carried in the mode field of a request.
   localparam logic [2:0] MODE_WRITE = 3'd0;
   localparam logic [2:0] MODE_READ  = 3'd1;
   localparam logic [2:0] MODE_RAISE = 3'd2;
   localparam logic [2:0] MODE_LOWER = 3'd3;
   localparam logic [2:0] MODE_ACK   = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_IS_MASTER = 1'b0;
   localparam logic CSR_HAS_SLAVE = 1'b1;

   // One request as it arrives on the input channel.
   typedef struct packed {
      logic [2:0] mode;
      logic       port;
      logic [7:0] wdata;
      logic [2:0] pin;
   } req_type;

   // One result as it leaves on the output channel.
   typedef struct packed {
      logic [7:0] rdata;
      logic       int_pulse;
      logic [7:0] vector;
      logic       from_slave;
   } rsp_type;

   // Static configuration shared by the top level and the core.
   typedef struct packed {
      logic is_master;
      logic has_slave;
   } cfg_type;

endpackage

`default_nettype wire

// ===== design/pic_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pic_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire pic_pkg::req_type item,
   input  wire pic_pkg::cfg_type cfg,
   output pic_pkg::rsp_type      result
);
   import pic_pkg::*;

   // Init-word sequencer steps.
   localparam logic [1:0] STEP_IDLE  = 2'd0;
   localparam logic [1:0] STEP_ICW2  = 2'd1;
   localparam logic [1:0] STEP_ICW3  = 2'd2;
   localparam logic [1:0] STEP_ICW4  = 2'd3;

   // OCW2 subcommands that are acted on.
   localparam logic [2:0] OCW2_NONSPECIFIC_EOI = 3'd1;
   localparam logic [2:0] OCW2_SPECIFIC_EOI    = 3'd3;

   logic [7:0] irr_ff, irr_in;
   logic [7:0] isr_ff, isr_in;
   logic [7:0] imr_ff, imr_in;
   logic [7:0] level_ff, level_in;
   logic       read_irr_ff, read_irr_in;
   logic [1:0] step_ff, step_in;
   logic       cascade_ff, cascade_in;
   logic       want_icw4_ff, want_icw4_in;
   logic       auto_eoi_ff, auto_eoi_in;
   logic [7:0] base_ff, base_in;
   logic [7:0] map_ff, map_in;

   logic [7:0] pin_bit;
   logic [2:0] ack_line;
   logic [7:0] ack_bit;
   logic [2:0] eoi_line;

   // Highest set line; an empty word gives line 0.
   function automatic logic [2:0] top_line(input logic [7:0] v);
      logic [2:0] n;
      n = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (v[i]) begin
            n = 3'(i);
         end
      end
      return n;
   endfunction

   // After an end of interrupt, the highest pending request may signal.
   function automatic logic signal_after_eoi(input logic [7:0] irr, input logic [7:0] isr);
      return (irr != 8'd0) && ((isr >> top_line(irr)) == 8'd0);
   endfunction

   assign pin_bit  = 8'b0000_0001 << item.pin;
   assign ack_line = top_line(irr_ff);
   assign ack_bit  = 8'b0000_0001 << ack_line;
   assign eoi_line = (item.wdata[7:5] == OCW2_SPECIFIC_EOI) ? item.wdata[2:0] : top_line(isr_ff);

   // Next state and result for the request in the input register.
   always_comb begin
      irr_in       = irr_ff;
      isr_in       = isr_ff;
      imr_in       = imr_ff;
      level_in     = level_ff;
      read_irr_in  = read_irr_ff;
      step_in      = step_ff;
      cascade_in   = cascade_ff;
      want_icw4_in = want_icw4_ff;
      auto_eoi_in  = auto_eoi_ff;
      base_in      = base_ff;
      map_in       = map_ff;
      result       = '0;
      unique case (item.mode)
         MODE_WRITE: begin
            if (!item.port) begin
               if (item.wdata[4]) begin
                  // ICW1 restarts the init sequence.
                  imr_in       = 8'd0;
                  cascade_in   = ~item.wdata[1];
                  want_icw4_in = item.wdata[0];
                  if (!item.wdata[0]) begin
                     auto_eoi_in = 1'b0;
                  end
                  step_in = STEP_ICW2;
               end else if (!item.wdata[3]) begin
                  // OCW2: only the two end-of-interrupt commands act.
                  if (item.wdata[7:5] == OCW2_NONSPECIFIC_EOI ||
                      item.wdata[7:5] == OCW2_SPECIFIC_EOI) begin
                     isr_in = isr_ff & ~(8'b0000_0001 << eoi_line);
                     result.int_pulse = signal_after_eoi(irr_ff, isr_in);
                  end
               end else if (item.wdata[1]) begin
                  // OCW3 read register select.
                  read_irr_in = item.wdata[0];
               end
            end else begin
               unique case (step_ff)
                  STEP_IDLE: begin
                     imr_in = item.wdata;
                  end
                  STEP_ICW2: begin
                     base_in = {item.wdata[7:3], 3'b000};
                     if (cascade_ff) begin
                        step_in = STEP_ICW3;
                     end else begin
                        map_in  = 8'd0;
                        step_in = STEP_IDLE;
                     end
                  end
                  STEP_ICW3: begin
                     map_in  = cfg.is_master ? item.wdata : {5'b00000, item.wdata[2:0]};
                     step_in = want_icw4_ff ? STEP_ICW4 : STEP_IDLE;
                  end
                  default: begin
                     auto_eoi_in = item.wdata[1];
                     step_in     = STEP_IDLE;
                  end
               endcase
            end
         end
         MODE_READ: begin
            if (!item.port) begin
               result.rdata = read_irr_ff ? irr_ff : isr_ff;
            end else begin
               result.rdata = imr_ff;
            end
         end
         MODE_RAISE: begin
            // Only a rising edge on an unmasked line latches a request.
            if ((level_ff & pin_bit) == 8'd0 && (imr_ff & pin_bit) == 8'd0) begin
               irr_in = irr_ff | pin_bit;
               result.int_pulse = (isr_ff >> item.pin) == 8'd0;
            end
            level_in = level_ff | pin_bit;
         end
         MODE_LOWER: begin
            level_in = level_ff & ~pin_bit;
         end
         MODE_ACK: begin
            irr_in = irr_ff & ~ack_bit;
            if (auto_eoi_ff) begin
               isr_in = isr_ff & ~ack_bit;
               result.int_pulse = signal_after_eoi(irr_in, isr_in);
            end else begin
               isr_in = isr_ff | ack_bit;
            end
            if (cfg.has_slave && (map_ff & ack_bit) != 8'd0) begin
               result.from_slave = 1'b1;
            end else begin
               result.vector = base_ff | {5'b00000, ack_line};
            end
         end
         default: begin
         end
      endcase
   end

   // Controller state, committed when the result moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         irr_ff       <= 8'd0;
         isr_ff       <= 8'd0;
         imr_ff       <= 8'd0;
         level_ff     <= 8'd0;
         read_irr_ff  <= 1'b1;
         step_ff      <= STEP_IDLE;
         cascade_ff   <= 1'b0;
         want_icw4_ff <= 1'b0;
         auto_eoi_ff  <= 1'b0;
         base_ff      <= 8'd0;
         map_ff       <= 8'd0;
      end else if (advance) begin
         irr_ff       <= irr_in;
         isr_ff       <= isr_in;
         imr_ff       <= imr_in;
         level_ff     <= level_in;
         read_irr_ff  <= read_irr_in;
         step_ff      <= step_in;
         cascade_ff   <= cascade_in;
         want_icw4_ff <= want_icw4_in;
         auto_eoi_ff  <= auto_eoi_in;
         base_ff      <= base_in;
         map_ff       <= map_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/programmable_interrupt_controller.sv =====
// Eight-line interrupt controller with fixed priority (line 7 highest).
// Requests arrive on the req_ channel (valid/ready): a register write or
// read at port 0 or 1, a pin raise, a pin lower, or an acknowledge. Each
// request yields exactly one result on the rsp_ channel carrying read data,
// the interrupt pulse, the vector and the cascade flag.
// A request is captured in an input register and, once the result
// register is free or being drained, evaluated against the controller
// state and written to the result register.
// One request per cycle is accepted while rsp_ready stays high; the path
// between registers is the 8-bit priority encode and the core state update.
// When the receiver holds rsp_ready low, the result register holds its
// value and the input register keeps the next request, so req_ready drops
// once both are full and rises again as soon as the result is taken.
// Reset (synchronous, active high) empties both registers, restores the
// controller state and sets the configuration to master without slave.
// The csr_ port writes is_master (index 0) or has_slave (index 1).
`timescale 1ns / 1ps
`default_nettype none

module programmable_interrupt_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pic_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pic_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_index,
   input  wire logic             csr_write_data
);
   import pic_pkg::*;

   logic    in_valid_ff;
   req_type in_item_ff;
   logic    out_valid_ff;
   rsp_type out_item_ff;
   cfg_type cfg_ff;
   rsp_type core_result;
   logic    advance;

   // The request moves on when the result register is free or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.is_master <= 1'b1;
         cfg_ff.has_slave <= 1'b0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_IS_MASTER) begin
            cfg_ff.is_master <= csr_write_data;
         end
         if (csr_index == CSR_HAS_SLAVE) begin
            cfg_ff.has_slave <= csr_write_data;
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_payload;
      end
   end

   pic_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (core_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

`default_nettype wire

// ===== design/pic_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pic_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire pic_pkg::rsp_type rsp_payload
);
   import pic_pkg::*;

   // An accepted request always finds rsp_valid high once past the input and result registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 rsp_valid)
      else $error("result missing two cycles after an accepted request");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

   // A slave-supplied vector leaves the vector and read data at zero.
   a_slave: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.from_slave) |->
      (rsp_payload.vector == 8'd0 && rsp_payload.rdata == 8'd0))
      else $error("slave acknowledge carries a vector or read data");

   // Read data only comes from a read, which neither pulses nor acknowledges.
   a_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.rdata != 8'd0) |->
      (!rsp_payload.int_pulse && rsp_payload.vector == 8'd0 && !rsp_payload.from_slave))
      else $error("read result mixed with other result fields");

   // Reset empties the result register.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind programmable_interrupt_controller pic_checker u_pic_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== tb/pic_response_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and register-write ports of the interrupt controller.
// It keeps its own copy of the controller registers, works out the result that each
// accepted request must produce, and compares results in order as they are taken.
module pic_response_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  pic_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  pic_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic             csr_write_data,
   output int               fail_count,
   output int               outstanding,
   output int               results_checked
);
   import pic_pkg::*;

   // Command field of an operation command word two.
   localparam logic [2:0] EOI_NONSPECIFIC = 3'd1;
   localparam logic [2:0] EOI_SPECIFIC    = 3'd3;

   // Position in the initialization word sequence.
   localparam logic [1:0] INIT_IDLE    = 2'd0;
   localparam logic [1:0] INIT_BASE    = 2'd1;
   localparam logic [1:0] INIT_CASCADE = 2'd2;
   localparam logic [1:0] INIT_MODE    = 2'd3;

   // Configuration as last written.
   logic       cfg_master;
   logic       cfg_slave;

   // Controller registers.
   logic [7:0] pending_lines;
   logic [7:0] serviced_lines;
   logic [7:0] line_mask;
   logic [7:0] pin_state;
   logic       show_pending;
   logic [1:0] init_phase;
   logic       cascade_on;
   logic       want_mode_word;
   logic       auto_eoi;
   logic [7:0] vector_base_q;
   logic [7:0] cascade_map_q;

   // Results still owed by the controller, oldest first.
   rsp_type    owed_results[$];
   rsp_type    want;
   int         failures = 0;
   int         checked = 0;
   int         owed = 0;

   assign fail_count      = failures;
   assign outstanding     = owed;
   assign results_checked = checked;

   // Highest set line; an empty vector picks line 0.
   function automatic logic [2:0] highest_line(input logic [7:0] v);
      logic [2:0] n;
      int         i;
      n = 3'd0;
      for (i = 0; i < 8; i++)
         if (v[i]) n = 3'(i);
      return n;
   endfunction

   // A line may interrupt when nothing of equal or higher number is in service.
   function automatic logic may_interrupt(input logic [2:0] ln);
      return (serviced_lines >> ln) == 8'd0;
   endfunction

   // End service of a line and see whether the top pending line can now interrupt.
   function automatic logic end_service(input logic [2:0] ln);
      serviced_lines[ln] = 1'b0;
      if (pending_lines != 8'd0) return may_interrupt(highest_line(pending_lines));
      return 1'b0;
   endfunction

   // Apply one request to the register copy and return the result it causes.
   function automatic rsp_type predict_response(input req_type r);
      rsp_type    y;
      logic [2:0] ln;
      logic [7:0] bit_sel;
      y = '0;
      bit_sel = 8'd1 << r.pin;
      case (r.mode)
         MODE_WRITE: begin
            if (!r.port) begin
               if (r.wdata[4]) begin
                  // First initialization word restarts the sequence.
                  line_mask = 8'd0;
                  cascade_on = !r.wdata[1];
                  want_mode_word = r.wdata[0];
                  if (!r.wdata[0]) auto_eoi = 1'b0;
                  init_phase = INIT_BASE;
               end else if (!r.wdata[3]) begin
                  case (r.wdata[7:5])
                     EOI_NONSPECIFIC: y.int_pulse = end_service(highest_line(serviced_lines));
                     EOI_SPECIFIC:    y.int_pulse = end_service(r.wdata[2:0]);
                     default: ;
                  endcase
               end else if (r.wdata[1]) begin
                  show_pending = r.wdata[0];
               end
            end else begin
               case (init_phase)
                  INIT_IDLE: line_mask = r.wdata;
                  INIT_BASE: begin
                     vector_base_q = {r.wdata[7:3], 3'b000};
                     if (cascade_on) begin
                        init_phase = INIT_CASCADE;
                     end else begin
                        cascade_map_q = 8'd0;
                        init_phase = INIT_IDLE;
                     end
                  end
                  INIT_CASCADE: begin
                     cascade_map_q = cfg_master ? r.wdata : {5'd0, r.wdata[2:0]};
                     init_phase = want_mode_word ? INIT_MODE : INIT_IDLE;
                  end
                  default: begin
                     auto_eoi = r.wdata[1];
                     init_phase = INIT_IDLE;
                  end
               endcase
            end
         end
         MODE_READ: begin
            if (!r.port) y.rdata = show_pending ? pending_lines : serviced_lines;
            else y.rdata = line_mask;
         end
         MODE_RAISE: begin
            // Only a rising edge on an unmasked line latches a request.
            if (!(pin_state & bit_sel) && !(line_mask & bit_sel)) begin
               pending_lines = pending_lines | bit_sel;
               y.int_pulse = may_interrupt(r.pin);
            end
            pin_state = pin_state | bit_sel;
         end
         MODE_LOWER: pin_state = pin_state & ~bit_sel;
         MODE_ACK: begin
            ln = highest_line(pending_lines);
            pending_lines[ln] = 1'b0;
            if (auto_eoi) y.int_pulse = end_service(ln);
            else serviced_lines[ln] = 1'b1;
            if (cfg_slave && cascade_map_q[ln]) y.from_slave = 1'b1;
            else y.vector = vector_base_q | {5'd0, ln};
         end
         default: ;
      endcase
      return y;
   endfunction

   // Compare taken results first, then record what a newly accepted request owes.
   always @(posedge clock) begin
      if (reset) begin
         cfg_master = 1'b1;
         cfg_slave = 1'b0;
         pending_lines = 8'd0;
         serviced_lines = 8'd0;
         line_mask = 8'd0;
         pin_state = 8'd0;
         show_pending = 1'b1;
         init_phase = INIT_IDLE;
         cascade_on = 1'b0;
         want_mode_word = 1'b0;
         auto_eoi = 1'b0;
         vector_base_q = 8'd0;
         cascade_map_q = 8'd0;
         owed_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IS_MASTER: cfg_master = csr_write_data;
               CSR_HAS_SLAVE: cfg_slave = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               failures++;
               $error("result %h taken with no request outstanding", rsp_payload);
            end else begin
               want = owed_results.pop_front();
               checked++;
               if (rsp_payload.rdata !== want.rdata) begin
                  failures++;
                  $error("rdata: expected %02h, got %02h", want.rdata, rsp_payload.rdata);
               end
               if (rsp_payload.int_pulse !== want.int_pulse) begin
                  failures++;
                  $error("int_pulse: expected %0b, got %0b",
                         want.int_pulse, rsp_payload.int_pulse);
               end
               if (rsp_payload.vector !== want.vector) begin
                  failures++;
                  $error("vector: expected %02h, got %02h", want.vector, rsp_payload.vector);
               end
               if (rsp_payload.from_slave !== want.from_slave) begin
                  failures++;
                  $error("from_slave: expected %0b, got %0b",
                         want.from_slave, rsp_payload.from_slave);
               end
            end
         end
         if (req_valid && req_ready) owed_results.push_back(predict_response(req_payload));
      end
      owed = owed_results.size();
   end

endmodule

// ===== tb/tb_programmable_interrupt_controller.sv =====
`timescale 1ns / 1ps

module tb_programmable_interrupt_controller;
   import pic_pkg::*;

   // Command field of an operation command word two.
   localparam logic [2:0] EOI_NONSPECIFIC = 3'd1;
   localparam logic [2:0] EOI_SPECIFIC    = 3'd3;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 217;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic    csr_write_enable = 1'b0;
   logic    csr_index = 1'b0;
   logic    csr_write_data = 1'b0;

   int fail_count;
   int outstanding;
   int results_checked;
   int sent_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles = 0;

   always #5 clock = ~clock;

   programmable_interrupt_controller u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   pic_response_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .results_checked  (results_checked)
   );

   // The result side stalls at random at the rate of the current phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // End the run if neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Present one request after a random gap and hold it until it is taken.
   task automatic issue(input logic [2:0] op, input logic prt, input logic [7:0] data,
                        input logic [2:0] ln);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{op, prt, data, ln};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   // Stop sending until every outstanding result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Change the master/slave setting while the controller is idle.
   task automatic set_config(input logic master, input logic slave);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_IS_MASTER;
      csr_write_data <= master;
      @(negedge clock);
      csr_index <= CSR_HAS_SLAVE;
      csr_write_data <= slave;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // One random operation; an initialization sequence counts as a single pick.
   task automatic send_random_op();
      int unsigned pick;
      logic [7:0]  bits;
      logic [7:0]  icw1;
      logic [2:0]  sub;
      pick = $urandom_range(99);
      bits = 8'($urandom);
      if (pick < 8) begin
         // Initialization words, now and then cut short.
         icw1 = bits | 8'h10;
         issue(MODE_WRITE, 1'b0, icw1, 3'($urandom));
         if ($urandom_range(9) != 0) begin
            issue(MODE_WRITE, 1'b1, 8'($urandom), 3'($urandom));
            if (!icw1[1] && $urandom_range(9) != 0) begin
               issue(MODE_WRITE, 1'b1, 8'($urandom), 3'($urandom));
               if (icw1[0] && $urandom_range(9) != 0)
                  issue(MODE_WRITE, 1'b1, 8'($urandom), 3'($urandom));
            end
         end
      end else if (pick < 30) begin
         issue(MODE_RAISE, 1'($urandom), 8'($urandom), 3'($urandom));
      end else if (pick < 45) begin
         issue(MODE_LOWER, 1'($urandom), 8'($urandom), 3'($urandom));
      end else if (pick < 62) begin
         issue(MODE_ACK, 1'($urandom), 8'($urandom), 3'($urandom));
      end else if (pick < 72) begin
         // End-of-interrupt commands, mostly the two that act.
         case ($urandom_range(3))
            0, 1: sub = EOI_NONSPECIFIC;
            2:    sub = EOI_SPECIFIC;
            default: sub = 3'($urandom);
         endcase
         issue(MODE_WRITE, 1'b0, {sub, 2'b00, bits[2:0]}, 3'($urandom));
      end else if (pick < 78) begin
         issue(MODE_WRITE, 1'b0, {bits[7:5], 2'b01, bits[2:0]}, 3'($urandom));
      end else if (pick < 88) begin
         issue(MODE_READ, 1'($urandom), 8'($urandom), 3'($urandom));
      end else if (pick < 94) begin
         issue(MODE_WRITE, 1'b1, bits & 8'($urandom), 3'($urandom));
      end else begin
         issue(3'($urandom_range(7)), 1'($urandom), bits, 3'($urandom));
      end
   endtask

   // A random phase at the given idle rates, with a full pause in the middle and now and then at random.
   task automatic run_phase(input int send_pct, input int recv_pct);
      int start_count;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start_count = sent_count;
      while (sent_count - start_count < PHASE_ITEMS) begin
         send_random_op();
         if (sent_count - start_count == PHASE_ITEMS / 2 || $urandom_range(99) == 0)
            drain_results();
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      set_config(1'b1, 1'b1);

      // Directed cases: empty picks, full init sequence, cascade, masking, EOI.
      send_idle_pct = 10;
      recv_idle_pct = 30;
      issue(MODE_READ, 1'b0, 8'h00, 3'd0);
      issue(MODE_ACK, 1'b0, 8'h00, 3'd0);
      issue(MODE_WRITE, 1'b0, {EOI_NONSPECIFIC, 5'd0}, 3'd7);
      issue(MODE_WRITE, 1'b0, {EOI_NONSPECIFIC, 5'd0}, 3'd0);
      issue(MODE_WRITE, 1'b0, 8'h11, 3'd0);
      issue(MODE_WRITE, 1'b1, 8'hFF, 3'd0);
      issue(MODE_WRITE, 1'b1, 8'h81, 3'd0);
      issue(MODE_WRITE, 1'b1, 8'h02, 3'd0);
      issue(MODE_RAISE, 1'b0, 8'h00, 3'd7);
      issue(MODE_RAISE, 1'b1, 8'hFF, 3'd7);
      issue(MODE_ACK, 1'b0, 8'h00, 3'd0);
      issue(MODE_RAISE, 1'b0, 8'h00, 3'd0);
      issue(MODE_ACK, 1'b1, 8'hFF, 3'd7);
      // Single mode without a mode word: the word after the base is a mask.
      issue(MODE_WRITE, 1'b0, 8'h12, 3'd0);
      issue(MODE_WRITE, 1'b1, 8'h20, 3'd0);
      issue(MODE_WRITE, 1'b1, 8'h01, 3'd0);
      issue(MODE_LOWER, 1'b0, 8'h00, 3'd0);
      issue(MODE_RAISE, 1'b0, 8'h00, 3'd0);
      issue(MODE_RAISE, 1'b0, 8'h00, 3'd3);
      issue(MODE_ACK, 1'b0, 8'h00, 3'd0);
      issue(MODE_RAISE, 1'b0, 8'h00, 3'd5);
      issue(MODE_RAISE, 1'b0, 8'h00, 3'd1);
      issue(MODE_WRITE, 1'b0, 8'h0A, 3'd0);
      issue(MODE_READ, 1'b0, 8'h00, 3'd0);
      issue(MODE_WRITE, 1'b0, {EOI_SPECIFIC, 5'd3}, 3'd0);
      issue(MODE_READ, 1'b1, 8'h00, 3'd0);
      issue(MODE_WRITE, 1'b0, 8'hA0, 3'd0);
      issue(3'd5, 1'b1, 8'hFF, 3'd7);
      issue(3'd7, 1'b0, 8'h00, 3'd0);

      set_config(1'b0, 1'b1);
      run_phase(21, 76);
      set_config(1'b1, 1'b0);
      run_phase(76, 21);
      set_config(1'b0, 1'b0);
      run_phase(0, 0);

      drain_results();
      repeat (10) @(posedge clock);
      $display("Sent %0d requests and checked %0d results: directed cases, then random",
               sent_count, results_checked);
      $display("traffic under three stall mixes and four master/slave settings.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
